// File: rtl/rms_pkg.sv
// Shared types, codes and helpers for the robot mission sequencer.
// No dependencies; every rtl module imports this package.
`default_nettype none

package rms_pkg;

  // Highest navigation action code plus one; barcode actions at or above it are rejected.
  localparam int NAV_KINDS = 4;
  localparam int TURN_W    = 4;

  // Barcode characters.
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // Event queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPW    = 1;
  localparam int QCW    = 2;

  localparam int ST_W = 10;

  // Mission state, one-hot.
  typedef enum logic [ST_W-1:0] {
    ST_BOOT      = 10'b00_0000_0001,
    ST_FOLLOW    = 10'b00_0000_0010,
    ST_JUNCTION  = 10'b00_0000_0100,
    ST_HUMP      = 10'b00_0000_1000,
    ST_OBST_STOP = 10'b00_0001_0000,
    ST_SCAN      = 10'b00_0010_0000,
    ST_BYPASS    = 10'b00_0100_0000,
    ST_SEARCH    = 10'b00_1000_0000,
    ST_STOPPED   = 10'b01_0000_0000,
    ST_FAULT     = 10'b10_0000_0000
  } st_t;

  // External state numbering.
  localparam logic [3:0] SN_BOOT      = 4'd0;
  localparam logic [3:0] SN_FOLLOW    = 4'd1;
  localparam logic [3:0] SN_JUNCTION  = 4'd2;
  localparam logic [3:0] SN_HUMP      = 4'd3;
  localparam logic [3:0] SN_OBST_STOP = 4'd4;
  localparam logic [3:0] SN_SCAN      = 4'd5;
  localparam logic [3:0] SN_BYPASS    = 4'd6;
  localparam logic [3:0] SN_SEARCH    = 4'd7;
  localparam logic [3:0] SN_STOPPED   = 4'd8;
  localparam logic [3:0] SN_FAULT     = 4'd9;

  // State groups used by the transition rules.
  localparam logic [ST_W-1:0] GRP_FOLLOW_HUMP = ST_FOLLOW | ST_HUMP;
  localparam logic [ST_W-1:0] GRP_RECOVER     = ST_JUNCTION | ST_OBST_STOP | ST_SCAN |
                                                ST_BYPASS | ST_SEARCH;
  localparam logic [ST_W-1:0] GRP_OBSTACLE    = ST_FOLLOW | ST_JUNCTION | ST_HUMP |
                                                ST_BYPASS | ST_SEARCH;
  localparam logic [ST_W-1:0] GRP_LOST        = ST_FOLLOW | ST_JUNCTION | ST_HUMP;

  typedef enum logic [3:0] {
    EV_START       = 4'd0,
    EV_BARCODE     = 4'd1,
    EV_JUNCTION    = 4'd2,
    EV_TURN_DONE   = 4'd3,
    EV_HUMP        = 4'd4,
    EV_HUMP_DONE   = 4'd5,
    EV_OBSTACLE    = 4'd6,
    EV_STOPPED     = 4'd7,
    EV_PROFILE     = 4'd8,
    EV_BYPASS_DONE = 4'd9,
    EV_LOST        = 4'd10,
    EV_REACQUIRED  = 4'd11,
    EV_STOP        = 4'd12,
    EV_RESUME      = 4'd13,
    EV_IMPACT      = 4'd14,
    EV_TIMEOUT     = 4'd15
  } evt_t;

  typedef enum logic [1:0] {
    RC_OK  = 2'd0,
    RC_IGN = 2'd1,
    RC_INV = 2'd2
  } rc_t;

  typedef enum logic [2:0] {
    MV_NONE   = 3'd0,
    MV_FOLLOW = 3'd1,
    MV_STOP   = 3'd2,
    MV_SLOW   = 3'd3,
    MV_NORMAL = 3'd4,
    MV_TURN   = 3'd5,
    MV_BYPASS = 3'd6,
    MV_SEARCH = 3'd7
  } mv_t;

  // Avoidance plans.
  localparam logic [2:0] PL_NONE     = 3'd0;
  localparam logic [2:0] PL_LEFT     = 3'd1;
  localparam logic [2:0] PL_RIGHT    = 3'd2;
  localparam logic [2:0] PL_REVERSE  = 3'd3;
  localparam logic [2:0] PL_CONTINUE = 3'd4;
  localparam logic [2:0] PL_STOP     = 3'd5;

  localparam logic [TURN_W-1:0] TURN_NONE = '0;

  // Classified event, front to back.
  typedef struct packed {
    evt_t              kind;
    logic [TURN_W-1:0] turn;
    logic              turn_ok;
    logic [7:0]        letter;
    logic              letter_ok;
    logic              rev;
    logic [2:0]        plan;
    logic              plan_ok;
    logic              exp_ok;
    st_t               exp_st;
  } ent_t;

  // One decision.
  typedef struct packed {
    rc_t               rc;
    logic [3:0]        prior;
    logic [3:0]        nstate;
    mv_t               mv;
    logic [TURN_W-1:0] turn;
    logic [2:0]        plan;
    logic              scan;
    logic              changed;
  } res_t;

  function automatic logic [3:0] state_num(input st_t s);
    logic [3:0] n;
    unique case (s)
      ST_BOOT:      n = SN_BOOT;
      ST_FOLLOW:    n = SN_FOLLOW;
      ST_JUNCTION:  n = SN_JUNCTION;
      ST_HUMP:      n = SN_HUMP;
      ST_OBST_STOP: n = SN_OBST_STOP;
      ST_SCAN:      n = SN_SCAN;
      ST_BYPASS:    n = SN_BYPASS;
      ST_SEARCH:    n = SN_SEARCH;
      ST_STOPPED:   n = SN_STOPPED;
      ST_FAULT:     n = SN_FAULT;
      default:      n = SN_BOOT;
    endcase
    return n;
  endfunction

  function automatic st_t num_state(input logic [3:0] n);
    st_t s;
    unique case (n)
      SN_BOOT:      s = ST_BOOT;
      SN_FOLLOW:    s = ST_FOLLOW;
      SN_JUNCTION:  s = ST_JUNCTION;
      SN_HUMP:      s = ST_HUMP;
      SN_OBST_STOP: s = ST_OBST_STOP;
      SN_SCAN:      s = ST_SCAN;
      SN_BYPASS:    s = ST_BYPASS;
      SN_SEARCH:    s = ST_SEARCH;
      SN_STOPPED:   s = ST_STOPPED;
      SN_FAULT:     s = ST_FAULT;
      default:      s = ST_BOOT;
    endcase
    return s;
  endfunction

  function automatic logic in_grp(input st_t s, input logic [ST_W-1:0] grp);
    return |(s & grp);
  endfunction

endpackage

`default_nettype wire

// File: rtl/robot_mission_sequencer.sv
// Robot mission sequencer top level: front classifier, event queue, back state machine.
// Depends on rms_pkg, rms_front, rms_queue and rms_back.
//
//   channel | direction | handshake           | beat
//   --------+-----------+---------------------+---------------------------------------
//   in      | to block  | in_valid / in_stall | event_kind, turn_action, code_letter,
//           |           |                     | code_reversed, plan_in, expired_state
//   out     | from block| out_valid/out_stall | result_code, prior_state, new_state,
//           |           |                     | motion_cmd, turn_out, plan_out,
//           |           |                     | scan_start, changed
//
// One event beat per cycle sustained while out_stall is low; each in beat gives
// exactly one out beat. Each event is registered in the queue, then in the result register.
// The rate is set by the back end's state update, one event per clock when not stalled.
// in_stall is high only while the two-entry queue is full, so the input side keeps
// moving while a finished result waits on out_stall.
// rst is synchronous: mission state and both saved states go to boot, the pending
// turn clears, the queue empties and out_valid drops.
`default_nettype none

module robot_mission_sequencer
  import rms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,

  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [3:0]        event_kind,
  input  wire logic [TURN_W-1:0] turn_action,
  input  wire logic [7:0]        code_letter,
  input  wire logic              code_reversed,
  input  wire logic [2:0]        plan_in,
  input  wire logic [3:0]        expired_state,

  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             result_code,
  output logic [3:0]             prior_state,
  output logic [3:0]             new_state,
  output logic [2:0]             motion_cmd,
  output logic [TURN_W-1:0]      turn_out,
  output logic [2:0]             plan_out,
  output logic                   scan_start,
  output logic                   changed
);

  logic push;
  logic pop;
  logic q_valid;
  logic q_full;
  ent_t ent_in;
  ent_t ent_head;
  res_t res;

  // Front: classification of the argument fields (ranges, letter window).
  rms_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .event_kind    (event_kind),
    .turn_action   (turn_action),
    .code_letter   (code_letter),
    .code_reversed (code_reversed),
    .plan_in       (plan_in),
    .expired_state (expired_state),
    .q_full        (q_full),
    .push          (push),
    .ent           (ent_in)
  );

  // Decouples the input handshake from output back-pressure.
  rms_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .ent_in  (ent_in),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .ent_out (ent_head)
  );

  // Back: priority events, then per-state transitions; owns the result register.
  rms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .ent       (ent_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign result_code = res.rc;
  assign prior_state = res.prior;
  assign new_state   = res.nstate;
  assign motion_cmd  = res.mv;
  assign turn_out    = res.turn;
  assign plan_out    = res.plan;
  assign scan_start  = res.scan;
  assign changed     = res.changed;

  // changed flag agrees with the two state fields
  a_changed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (changed == (prior_state != new_state)))
    else $error("changed flag disagrees with state fields");

  // a non-accepted event moves nothing
  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (result_code != RC_OK)) |->
      ((motion_cmd == MV_NONE) && !changed && (turn_out == TURN_NONE) &&
       (plan_out == PL_NONE) && !scan_start))
    else $error("rejected event produced an action");

  // scan only starts on the obstacle-stop to scan transition
  a_scan_entry: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scan_start) |->
      ((prior_state == SN_OBST_STOP) && (new_state == SN_SCAN)))
    else $error("scan_start outside obstacle-stop exit");

  // a queue that has room never stalls the input
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full)
    else $error("input stalled with room in the queue");

endmodule

`default_nettype wire

// File: rtl/rms_front.sv
// Front end: takes event beats and classifies their arguments.
// Depends on rms_pkg; feeds rms_queue.
`default_nettype none

module rms_front
  import rms_pkg::*;
(
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [3:0]        event_kind,
  input  wire logic [TURN_W-1:0] turn_action,
  input  wire logic [7:0]        code_letter,
  input  wire logic              code_reversed,
  input  wire logic [2:0]        plan_in,
  input  wire logic [3:0]        expired_state,
  input  wire logic              q_full,
  output logic                   push,
  output ent_t                   ent
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    ent.kind      = evt_t'(event_kind);
    ent.turn      = turn_action;
    ent.turn_ok   = {1'b0, turn_action} < (TURN_W + 1)'(NAV_KINDS);
    ent.letter    = code_letter;
    ent.letter_ok = (code_letter >= CH_A) && (code_letter <= CH_Z);
    ent.rev       = code_reversed;
    ent.plan      = plan_in;
    ent.plan_ok   = (plan_in <= PL_STOP);
    ent.exp_ok    = (expired_state <= SN_FAULT);
    ent.exp_st    = num_state(expired_state);
  end

endmodule

`default_nettype wire

// File: rtl/rms_queue.sv
// Two-entry event queue between front and back.
// Depends on rms_pkg.
`default_nettype none

module rms_queue
  import rms_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire ent_t ent_in,
  input  wire logic pop,
  output logic      q_valid,
  output logic      q_full,
  output ent_t      ent_out
);

  ent_t             entries [QDEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic [QCW-1:0]   count_next;

  assign q_valid = (count != '0);
  assign q_full  = (count == QCW'(QDEPTH));
  assign ent_out = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= ent_in;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rms_back.sv
// Back end: mission state machine, saved states, pending turn, result register.
// Depends on rms_pkg; pops rms_queue.
`default_nettype none

module rms_back
  import rms_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire ent_t ent,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      res
);

  st_t               st, st_next;
  st_t               sv_stop, sv_stop_next;
  st_t               sv_obs, sv_obs_next;
  logic [TURN_W-1:0] pend_turn, pend_turn_next;
  logic [7:0]        pend_letter, pend_letter_next;
  logic              pend_rev, pend_rev_next;
  logic              pend_flag, pend_flag_next;
  res_t              res_next;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    rc_t               rc;
    mv_t               mv;
    logic [TURN_W-1:0] turn_o;
    logic [2:0]        plan_o;
    logic              scan_o;

    rc               = RC_IGN;
    mv               = MV_NONE;
    turn_o           = TURN_NONE;
    plan_o           = PL_NONE;
    scan_o           = 1'b0;
    st_next          = st;
    sv_stop_next     = sv_stop;
    sv_obs_next      = sv_obs;
    pend_turn_next   = pend_turn;
    pend_letter_next = pend_letter;
    pend_rev_next    = pend_rev;
    pend_flag_next   = pend_flag;

    unique case (ent.kind)
      EV_IMPACT: begin
        st_next = ST_FAULT;
        mv      = MV_STOP;
        rc      = RC_OK;
      end
      EV_STOP: begin
        mv = MV_STOP;
        rc = RC_OK;
        if (st != ST_FAULT) begin
          if (st != ST_STOPPED) begin
            sv_stop_next = st;
          end
          st_next = ST_STOPPED;
        end
      end
      EV_RESUME: begin
        if (st == ST_STOPPED) begin
          if (in_grp(sv_stop, GRP_FOLLOW_HUMP)) begin
            st_next = ST_FOLLOW;
            mv      = MV_FOLLOW;
            rc      = RC_OK;
          end else if (in_grp(sv_stop, GRP_RECOVER)) begin
            st_next = ST_SEARCH;
            mv      = MV_SEARCH;
            rc      = RC_OK;
          end
        end
      end
      EV_TIMEOUT: begin
        if (!ent.exp_ok) begin
          rc = RC_INV;
        end else if ((ent.exp_st == st) && in_grp(st, GRP_RECOVER)) begin
          st_next = ST_FAULT;
          mv      = MV_STOP;
          rc      = RC_OK;
        end
      end
      EV_BARCODE: begin
        if (!ent.turn_ok) begin
          rc = RC_INV;
        end else if (in_grp(st, GRP_FOLLOW_HUMP) && ent.letter_ok &&
                     (ent.turn != TURN_NONE)) begin
          pend_turn_next   = ent.turn;
          pend_letter_next = ent.letter;
          pend_rev_next    = ent.rev;
          pend_flag_next   = 1'b1;
          rc               = RC_OK;
        end
      end
      EV_OBSTACLE: begin
        if (in_grp(st, GRP_OBSTACLE)) begin
          sv_obs_next = st;
          st_next     = ST_OBST_STOP;
          mv          = MV_STOP;
          rc          = RC_OK;
        end
      end
      EV_LOST: begin
        if (in_grp(st, GRP_LOST)) begin
          st_next = ST_SEARCH;
          mv      = MV_SEARCH;
          rc      = RC_OK;
        end
      end
      EV_START: begin
        if (st == ST_BOOT) begin
          st_next = ST_FOLLOW;
          mv      = MV_FOLLOW;
          rc      = RC_OK;
        end
      end
      EV_JUNCTION: begin
        if (st == ST_FOLLOW) begin
          rc = RC_OK;
          if (!pend_flag) begin
            // junction with no turn on record
            st_next = ST_FAULT;
            mv      = MV_STOP;
          end else begin
            st_next        = ST_JUNCTION;
            mv             = MV_TURN;
            turn_o         = pend_turn;
            pend_turn_next = TURN_NONE;
            pend_flag_next = 1'b0;
          end
        end
      end
      EV_HUMP: begin
        if (st == ST_FOLLOW) begin
          st_next = ST_HUMP;
          mv      = MV_SLOW;
          rc      = RC_OK;
        end
      end
      EV_TURN_DONE: begin
        if (st == ST_JUNCTION) begin
          st_next = ST_FOLLOW;
          mv      = MV_FOLLOW;
          rc      = RC_OK;
        end
      end
      EV_HUMP_DONE: begin
        if (st == ST_HUMP) begin
          st_next = ST_FOLLOW;
          mv      = MV_NORMAL;
          rc      = RC_OK;
        end
      end
      EV_STOPPED: begin
        if (st == ST_OBST_STOP) begin
          st_next = ST_SCAN;
          scan_o  = 1'b1;
          rc      = RC_OK;
        end
      end
      EV_PROFILE: begin
        if (st == ST_SCAN) begin
          if (!ent.plan_ok) begin
            rc = RC_INV;
          end else if ((ent.plan == PL_LEFT) || (ent.plan == PL_RIGHT) ||
                       (ent.plan == PL_REVERSE)) begin
            st_next = ST_BYPASS;
            mv      = MV_BYPASS;
            plan_o  = ent.plan;
            rc      = RC_OK;
          end else if (ent.plan == PL_CONTINUE) begin
            rc = RC_OK;
            if (sv_obs == ST_FOLLOW) begin
              st_next = ST_FOLLOW;
              mv      = MV_FOLLOW;
            end else begin
              st_next = ST_SEARCH;
              mv      = MV_SEARCH;
            end
          end else if (ent.plan == PL_STOP) begin
            sv_stop_next = ST_SCAN;
            st_next      = ST_STOPPED;
            mv           = MV_STOP;
            rc           = RC_OK;
          end
        end
      end
      EV_BYPASS_DONE: begin
        if (st == ST_BYPASS) begin
          st_next = ST_SEARCH;
          mv      = MV_SEARCH;
          rc      = RC_OK;
        end
      end
      EV_REACQUIRED: begin
        if (st == ST_SEARCH) begin
          st_next = ST_FOLLOW;
          mv      = MV_FOLLOW;
          rc      = RC_OK;
        end
      end
      default: begin
        rc = RC_IGN;
      end
    endcase

    res_next.rc      = rc;
    res_next.prior   = state_num(st);
    res_next.nstate  = state_num(st_next);
    res_next.mv      = mv;
    res_next.turn    = turn_o;
    res_next.plan    = plan_o;
    res_next.scan    = scan_o;
    res_next.changed = (st_next != st);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_BOOT;
      sv_stop     <= ST_BOOT;
      sv_obs      <= ST_BOOT;
      pend_turn   <= TURN_NONE;
      pend_letter <= CH_QMARK;
      pend_rev    <= 1'b0;
      pend_flag   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        st          <= st_next;
        sv_stop     <= sv_stop_next;
        sv_obs      <= sv_obs_next;
        pend_turn   <= pend_turn_next;
        pend_letter <= pend_letter_next;
        pend_rev    <= pend_rev_next;
        pend_flag   <= pend_flag_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_robot_mission_sequencer.sv
`timescale 1ns / 1ps
// Testbench for robot_mission_sequencer: event beats in, one decision beat out per event.
// Depends on rms_pkg and the rtl; holds its own mission predictor and decision scoreboard.

import rms_pkg::*;

typedef struct {
  evt_t       kind;
  logic [3:0] turn;
  logic [7:0] letter;
  logic       rev;
  logic [2:0] plan;
  logic [3:0] expired;
} mission_evt_t;

class mission_scoreboard;
  // predicted block state
  logic [3:0] mstate      = SN_BOOT;
  logic [3:0] saved_stop  = SN_BOOT;
  logic [3:0] saved_obst  = SN_BOOT;
  logic [3:0] pend_turn   = TURN_NONE;
  logic [7:0] pend_letter = CH_QMARK;
  logic       pend_rev    = 1'b0;
  logic       turn_armed  = 1'b0;

  bit [9:0] follow_hump_set = (10'd1 << SN_FOLLOW) | (10'd1 << SN_HUMP);
  bit [9:0] recover_set     = (10'd1 << SN_JUNCTION) | (10'd1 << SN_OBST_STOP) |
                              (10'd1 << SN_SCAN) | (10'd1 << SN_BYPASS) |
                              (10'd1 << SN_SEARCH);
  bit [9:0] obstacle_set    = (10'd1 << SN_FOLLOW) | (10'd1 << SN_JUNCTION) |
                              (10'd1 << SN_HUMP) | (10'd1 << SN_BYPASS) |
                              (10'd1 << SN_SEARCH);
  bit [9:0] lost_set        = (10'd1 << SN_FOLLOW) | (10'd1 << SN_JUNCTION) |
                              (10'd1 << SN_HUMP);

  res_t decisions_due[$];
  int   mismatches;
  int   events_seen;
  int   checked;
  int   n_ok, n_ign, n_inv;
  bit [9:0] visited;

  function bit member(logic [3:0] s, bit [9:0] set);
    return (s <= SN_FAULT) && set[s];
  endfunction

  // Events that would lock the block in fault (or stopped-from-boot) for good.
  function bit leads_to_trap(mission_evt_t e);
    return (e.kind == EV_IMPACT) ||
           (e.kind == EV_STOP && mstate == SN_BOOT) ||
           (e.kind == EV_TIMEOUT && e.expired == mstate && member(mstate, recover_set)) ||
           (e.kind == EV_JUNCTION && mstate == SN_FOLLOW && !turn_armed);
  endfunction

  function res_t predict_decision(mission_evt_t e);
    res_t d;
    logic [3:0] s;
    s = mstate;
    d = '0;
    d.rc = RC_IGN;
    d.prior = s;
    d.nstate = s;
    d.mv = MV_NONE;
    d.turn = TURN_NONE;
    d.plan = PL_NONE;
    case (e.kind)
      EV_IMPACT: begin
        d.rc = RC_OK; d.nstate = SN_FAULT; d.mv = MV_STOP;
      end
      EV_STOP: begin
        d.rc = RC_OK;
        d.mv = MV_STOP;
        if (s != SN_FAULT) begin
          if (s != SN_STOPPED) saved_stop = s;
          d.nstate = SN_STOPPED;
        end
      end
      EV_RESUME: begin
        if (s == SN_STOPPED && member(saved_stop, follow_hump_set)) begin
          d.rc = RC_OK; d.nstate = SN_FOLLOW; d.mv = MV_FOLLOW;
        end else if (s == SN_STOPPED && member(saved_stop, recover_set)) begin
          d.rc = RC_OK; d.nstate = SN_SEARCH; d.mv = MV_SEARCH;
        end
      end
      EV_TIMEOUT: begin
        if (e.expired > SN_FAULT) begin
          d.rc = RC_INV;
        end else if (e.expired == s && member(s, recover_set)) begin
          d.rc = RC_OK; d.nstate = SN_FAULT; d.mv = MV_STOP;
        end
      end
      EV_BARCODE: begin
        if (e.turn >= NAV_KINDS) begin
          d.rc = RC_INV;
        end else if (member(s, follow_hump_set) && e.letter >= CH_A && e.letter <= CH_Z &&
                     e.turn != TURN_NONE) begin
          d.rc = RC_OK;
          pend_turn = e.turn;
          pend_letter = e.letter;
          pend_rev = e.rev;
          turn_armed = 1'b1;
        end
      end
      EV_OBSTACLE: begin
        if (member(s, obstacle_set)) begin
          saved_obst = s;
          d.rc = RC_OK; d.nstate = SN_OBST_STOP; d.mv = MV_STOP;
        end
      end
      EV_LOST: begin
        if (member(s, lost_set)) begin
          d.rc = RC_OK; d.nstate = SN_SEARCH; d.mv = MV_SEARCH;
        end
      end
      default: begin
        case (s)
          SN_BOOT: if (e.kind == EV_START) begin
            d.rc = RC_OK; d.nstate = SN_FOLLOW; d.mv = MV_FOLLOW;
          end
          SN_FOLLOW: begin
            if (e.kind == EV_JUNCTION) begin
              d.rc = RC_OK;
              if (!turn_armed) begin
                d.nstate = SN_FAULT; d.mv = MV_STOP;
              end else begin
                d.nstate = SN_JUNCTION; d.mv = MV_TURN; d.turn = pend_turn;
                pend_turn = TURN_NONE;
                turn_armed = 1'b0;
              end
            end else if (e.kind == EV_HUMP) begin
              d.rc = RC_OK; d.nstate = SN_HUMP; d.mv = MV_SLOW;
            end
          end
          SN_JUNCTION: if (e.kind == EV_TURN_DONE) begin
            d.rc = RC_OK; d.nstate = SN_FOLLOW; d.mv = MV_FOLLOW;
          end
          SN_HUMP: if (e.kind == EV_HUMP_DONE) begin
            d.rc = RC_OK; d.nstate = SN_FOLLOW; d.mv = MV_NORMAL;
          end
          SN_OBST_STOP: if (e.kind == EV_STOPPED) begin
            d.rc = RC_OK; d.nstate = SN_SCAN; d.mv = MV_NONE; d.scan = 1'b1;
          end
          SN_SCAN: if (e.kind == EV_PROFILE) begin
            if (e.plan > PL_STOP) begin
              d.rc = RC_INV;
            end else if (e.plan >= PL_LEFT && e.plan <= PL_REVERSE) begin
              d.rc = RC_OK; d.nstate = SN_BYPASS; d.mv = MV_BYPASS; d.plan = e.plan;
            end else if (e.plan == PL_CONTINUE) begin
              d.rc = RC_OK;
              if (saved_obst == SN_FOLLOW) begin
                d.nstate = SN_FOLLOW; d.mv = MV_FOLLOW;
              end else begin
                d.nstate = SN_SEARCH; d.mv = MV_SEARCH;
              end
            end else if (e.plan == PL_STOP) begin
              saved_stop = SN_SCAN;
              d.rc = RC_OK; d.nstate = SN_STOPPED; d.mv = MV_STOP;
            end
          end
          SN_BYPASS: if (e.kind == EV_BYPASS_DONE) begin
            d.rc = RC_OK; d.nstate = SN_SEARCH; d.mv = MV_SEARCH;
          end
          SN_SEARCH: if (e.kind == EV_REACQUIRED) begin
            d.rc = RC_OK; d.nstate = SN_FOLLOW; d.mv = MV_FOLLOW;
          end
          default: ;
        endcase
      end
    endcase
    mstate = d.nstate;
    d.changed = (d.nstate != s);
    return d;
  endfunction

  function void note_event(mission_evt_t e);
    visited[mstate] = 1'b1;
    events_seen++;
    decisions_due.push_back(predict_decision(e));
  endfunction

  function void flag(string field, int idx, logic [7:0] want, logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at decision %0d: expected %0d, got %0d", field, idx, want, got);
  endfunction

  function void check_decision(res_t got);
    res_t want;
    if (decisions_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("decision with no event outstanding: rc %0d state %0d->%0d motion %0d",
                 got.rc, got.prior, got.nstate, got.mv);
      return;
    end
    want = decisions_due.pop_front();
    case (want.rc)
      RC_OK:   n_ok++;
      RC_IGN:  n_ign++;
      default: n_inv++;
    endcase
    if (got.rc !== want.rc)           flag("result_code", checked, want.rc, got.rc);
    if (got.prior !== want.prior)     flag("prior_state", checked, want.prior, got.prior);
    if (got.nstate !== want.nstate)   flag("new_state", checked, want.nstate, got.nstate);
    if (got.mv !== want.mv)           flag("motion_cmd", checked, want.mv, got.mv);
    if (got.turn !== want.turn)       flag("turn_out", checked, want.turn, got.turn);
    if (got.plan !== want.plan)       flag("plan_out", checked, want.plan, got.plan);
    if (got.scan !== want.scan)       flag("scan_start", checked, want.scan, got.scan);
    if (got.changed !== want.changed) flag("changed", checked, want.changed, got.changed);
    checked++;
  endfunction
endclass

module tb_robot_mission_sequencer;

  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_FROM   = 1300;   // no idling on either side from here on
  localparam int HOLD_AT      = 500;    // beat index where the long receiver hold starts
  localparam int HOLD_CYCLES  = 48;
  localparam int DRAIN_CYCLES = 8;      // drain margin after the last expected decision
  localparam int CYCLE_LIMIT  = 100000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;

  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [3:0] event_kind    = EV_START;
  logic [3:0] turn_action   = TURN_NONE;
  logic [7:0] code_letter   = CH_QMARK;
  logic       code_reversed = 1'b0;
  logic [2:0] plan_in       = PL_NONE;
  logic [3:0] expired_state = SN_BOOT;

  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [1:0] result_code;
  logic [3:0] prior_state;
  logic [3:0] new_state;
  logic [2:0] motion_cmd;
  logic [3:0] turn_out;
  logic [2:0] plan_out;
  logic       scan_start;
  logic       changed;

  mission_scoreboard sb;

  // idling controls, set by the stimulus process
  bit tx_jitter = 1'b0;
  bit rx_jitter = 1'b0;
  bit hold_req  = 1'b0;

  int cycles;
  int held_in_cycles;
  int fault_mode;

  always #2 clk = ~clk;

  robot_mission_sequencer DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .event_kind(event_kind),
    .turn_action(turn_action),
    .code_letter(code_letter),
    .code_reversed(code_reversed),
    .plan_in(plan_in),
    .expired_state(expired_state),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_code(result_code),
    .prior_state(prior_state),
    .new_state(new_state),
    .motion_cmd(motion_cmd),
    .turn_out(turn_out),
    .plan_out(plan_out),
    .scan_start(scan_start),
    .changed(changed)
  );

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------
  function automatic mission_evt_t mk(evt_t kind, int turn, int letter, int rev,
                                      int plan, int expired);
    mission_evt_t e;
    e.kind = kind;
    e.turn = turn[3:0];
    e.letter = letter[7:0];
    e.rev = rev[0];
    e.plan = plan[2:0];
    e.expired = expired[3:0];
    return e;
  endfunction

  // Every field fully random, kind included.
  function automatic mission_evt_t noise_event();
    mission_evt_t e;
    logic [3:0] k;
    k = 4'($urandom_range(0, 15));
    e.kind = evt_t'(k);
    e.turn = 4'($urandom_range(0, 15));
    e.letter = 8'($urandom_range(0, 255));
    e.rev = 1'($urandom_range(0, 1));
    e.plan = 3'($urandom_range(0, 7));
    e.expired = 4'($urandom_range(0, 15));
    return e;
  endfunction

  // Barcode that is usually well formed, sometimes off in letter or action.
  function automatic mission_evt_t barcode_beat(mission_evt_t e);
    e.kind = EV_BARCODE;
    if ($urandom_range(0, 9) < 8) e.letter = 8'($urandom_range(CH_A, CH_Z));
    if ($urandom_range(0, 9) < 8) e.turn = 4'($urandom_range(1, NAV_KINDS - 1));
    return e;
  endfunction

  // An event that makes sense for the current mission state, random content.
  // Keeps the mission moving through hump, junction, obstacle and stop paths.
  function automatic mission_evt_t mission_step(logic [3:0] s, logic armed);
    mission_evt_t e;
    int pick;
    e = noise_event();
    pick = $urandom_range(0, 99);
    case (s)
      SN_BOOT: e.kind = EV_START;
      SN_FOLLOW: begin
        if (armed && pick < 50)  e.kind = EV_JUNCTION;
        else if (pick < 60)      e = barcode_beat(e);
        else if (pick < 75)      e.kind = EV_HUMP;
        else if (pick < 87)      e.kind = EV_OBSTACLE;
        else if (pick < 94)      e.kind = EV_LOST;
        else                     e.kind = EV_STOP;
        // without a pending turn, barcodes dominate so junctions become possible
        if (!armed && pick < 50) e = barcode_beat(e);
      end
      SN_JUNCTION: begin
        if (pick < 70)      e.kind = EV_TURN_DONE;
        else if (pick < 80) e.kind = EV_OBSTACLE;
        else if (pick < 90) e.kind = EV_LOST;
        else                e.kind = EV_STOP;
      end
      SN_HUMP: begin
        if (pick < 50)      e.kind = EV_HUMP_DONE;
        else if (pick < 70) e = barcode_beat(e);
        else if (pick < 80) e.kind = EV_OBSTACLE;
        else if (pick < 90) e.kind = EV_LOST;
        else                e.kind = EV_STOP;
      end
      SN_OBST_STOP: e.kind = (pick < 85) ? EV_STOPPED : EV_STOP;
      SN_SCAN:      e.kind = (pick < 85) ? EV_PROFILE : EV_STOP;  // plan stays random
      SN_BYPASS: begin
        if (pick < 70)      e.kind = EV_BYPASS_DONE;
        else if (pick < 85) e.kind = EV_OBSTACLE;
        else                e.kind = EV_STOP;
      end
      SN_SEARCH: begin
        if (pick < 70)      e.kind = EV_REACQUIRED;
        else if (pick < 85) e.kind = EV_OBSTACLE;
        else                e.kind = EV_STOP;
      end
      SN_STOPPED: e.kind = (pick < 85) ? EV_RESUME : EV_STOP;
      default: ;
    endcase
    return e;
  endfunction

  // Shortest way back to follow; used to set up the closing fault entry.
  function automatic mission_evt_t toward_follow(logic [3:0] s);
    mission_evt_t e;
    e = noise_event();
    case (s)
      SN_BOOT:      e.kind = EV_START;
      SN_FOLLOW:    e.kind = EV_JUNCTION;    // only used while a turn is pending
      SN_JUNCTION:  e.kind = EV_TURN_DONE;
      SN_HUMP:      e.kind = EV_HUMP_DONE;
      SN_OBST_STOP: e.kind = EV_STOPPED;
      SN_SCAN: begin
        e.kind = EV_PROFILE;
        e.plan = PL_LEFT;
      end
      SN_BYPASS:    e.kind = EV_BYPASS_DONE;
      SN_SEARCH:    e.kind = EV_REACQUIRED;
      default:      e.kind = EV_RESUME;      // stopped, saved state is always resumable
    endcase
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: called at a falling edge, returns at the falling edge after
  // the beat was taken. Payload holds while in_stall is high.
  // ---------------------------------------------------------------------------
  task automatic send_event(input mission_evt_t e);
    if (tx_jitter && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    event_kind    <= e.kind;
    turn_action   <= e.turn;
    code_letter   <= e.letter;
    code_reversed <= e.rev;
    plan_in       <= e.plan;
    expired_state <= e.expired;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold so the
  // two-entry queue fills and in_stall has to rise.
  // ---------------------------------------------------------------------------
  initial begin : out_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0)
        stall_left--;
      else if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (rx_jitter && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 4);
      out_stall <= (stall_left > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both channels sampled at the rising edge, pre-update values.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    res_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got.rc = rc_t'(result_code);
        got.prior = prior_state;
        got.nstate = new_state;
        got.mv = mv_t'(motion_cmd);
        got.turn = turn_out;
        got.plan = plan_out;
        got.scan = scan_start;
        got.changed = changed;
        sb.check_decision(got);
      end
      if (in_valid && !in_stall)
        sb.note_event(mk(evt_t'(event_kind), turn_action, code_letter, code_reversed,
                         plan_in, expired_state));
      if (in_valid && in_stall) held_in_cycles++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d decisions outstanding", cycles,
               sb.decisions_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    mission_evt_t e;
    sb = new;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed walk through the mission, edges of each field on the way.
    send_event(mk(EV_RESUME, TURN_NONE, 0, 0, PL_NONE, SN_BOOT));       // nothing to resume
    send_event(mk(EV_TIMEOUT, 15, 255, 1, 7, 15));                      // bad timer state
    send_event(mk(EV_START, TURN_NONE, CH_QMARK, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_BARCODE, 15, CH_A, 0, PL_NONE, SN_BOOT));          // bad action wins
    send_event(mk(EV_BARCODE, 1, CH_A - 1, 1, PL_NONE, SN_BOOT));       // letter below A
    send_event(mk(EV_BARCODE, 2, CH_Z + 1, 0, PL_NONE, SN_BOOT));       // letter above Z
    send_event(mk(EV_BARCODE, TURN_NONE, CH_A + 12, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_BARCODE, NAV_KINDS - 1, CH_Z, 1, PL_NONE, SN_BOOT));
    send_event(mk(EV_HUMP, 0, 0, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_HUMP_DONE, 0, 0, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_JUNCTION, 0, 0, 0, PL_NONE, SN_BOOT));            // takes pending turn
    send_event(mk(EV_TURN_DONE, 0, 0, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_TIMEOUT, 0, 0, 0, PL_NONE, SN_JUNCTION));          // stale timer
    send_event(mk(EV_OBSTACLE, 0, 0, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_STOPPED, 0, 0, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_PROFILE, 0, 0, 0, 7, SN_BOOT));                    // bad plan
    send_event(mk(EV_PROFILE, 0, 0, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_PROFILE, 0, 0, 0, PL_CONTINUE, SN_BOOT));          // back to follow
    send_event(mk(EV_LOST, 0, 0, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_OBSTACLE, 0, 0, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_STOPPED, 0, 0, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_PROFILE, 0, 0, 0, PL_STOP, SN_BOOT));              // scan -> stopped
    send_event(mk(EV_STOP, 0, 0, 0, PL_NONE, SN_BOOT));                 // stop while stopped
    send_event(mk(EV_RESUME, 0, 0, 0, PL_NONE, SN_BOOT));               // resumes to search
    send_event(mk(EV_REACQUIRED, 0, 0, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_STOP, 0, 0, 0, PL_NONE, SN_BOOT));
    send_event(mk(EV_RESUME, 0, 0, 0, PL_NONE, SN_BOOT));

    // Random part: mostly sensible mission steps, some noise. Anything that
    // would wedge the block in fault is held back for the closing section.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        tx_jitter = (i < QUIET_FROM) && ($urandom_range(0, 3) != 0);
        rx_jitter = (i < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      end
      if (i == HOLD_AT) hold_req = 1'b1;
      do begin
        if ($urandom_range(0, 9) < 7) e = mission_step(sb.mstate, sb.turn_armed);
        else e = noise_event();
      end while (sb.leads_to_trap(e));
      send_event(e);
    end

    // Closing: enter fault one way (picked at random), then every event kind
    // once more while faulted. Fault is only left by reset.
    fault_mode = $urandom_range(0, 2);
    if (fault_mode == 0) begin
      // junction with no pending turn
      while (!(sb.mstate == SN_FOLLOW && !sb.turn_armed)) send_event(toward_follow(sb.mstate));
      send_event(mk(EV_JUNCTION, 0, 0, 0, PL_NONE, SN_BOOT));
    end else if (fault_mode == 1) begin
      // timer runs out in the state it was armed for
      while (sb.mstate != SN_FOLLOW) send_event(toward_follow(sb.mstate));
      send_event(mk(EV_LOST, 0, 0, 0, PL_NONE, SN_BOOT));
      send_event(mk(EV_TIMEOUT, 0, 0, 0, PL_NONE, SN_SEARCH));
    end else begin
      send_event(mk(EV_IMPACT, 0, 0, 0, PL_NONE, SN_BOOT));
    end
    for (int k = 0; k < 16; k++) begin
      e = noise_event();
      e.kind = evt_t'(k[3:0]);
      send_event(e);
    end
    in_valid <= 1'b0;

    while (sb.decisions_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.decisions_due.size() != 0) sb.mismatches++;

    $display("ran %0d events, checked %0d decisions (%0d accepted, %0d ignored, %0d invalid)",
             sb.events_seen, sb.checked, sb.n_ok, sb.n_ign, sb.n_inv);
    $display("%0d of 10 mission states reached, input held off %0d cycles,",
             $countones(sb.visited), held_in_cycles);
    $display("fault path %0d, %0d field errors", fault_mode, sb.mismatches);
    if (sb.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
